@@ sv/mbe_pkg.sv @@
// Shared types and fixed-point constants for the Mandelbrot escape-time unit.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W - FRAC_BITS + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
    localparam int RESET_LIMIT = 16;

    // |re| or |im| at or above 4.0 escapes at once
    localparam logic signed [SUM_W-1:0] BOUND_POS = SUM_W'(64'sd1 <<< (FRAC_BITS + 2));
    localparam logic signed [SUM_W-1:0] BOUND_NEG = -BOUND_POS;
    // |z|^2 above 8.0 escapes
    localparam logic signed [SUM_W-1:0] ESC_LIMIT = SUM_W'(64'sd8 <<< FRAC_BITS);

    typedef struct packed {
        logic [COORD_W-1:0] c_real;
        logic [COORD_W-1:0] c_imag;
        logic               zero_limit;
    } t_job;

endpackage

@@ sv/mbe_front.sv @@
// Input stage: takes points, tags zero-limit jobs, hands them to the queue.
`timescale 1ns / 1ps

module mbe_front import mbe_pkg::*; #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COORD_W-1:0]     i_c_real,
    input  logic [COORD_W-1:0]     i_c_imag,
    input  logic [COUNT_WIDTH-1:0] i_limit,
    output logic                   o_push,
    output t_job                   o_job,
    input  logic                   i_queue_full
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic w_accept;

    assign o_in_stall = r_valid && i_queue_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_queue_full;
    assign o_job      = r_job;

    always_comb begin
        n_valid = (r_valid && i_queue_full) || w_accept;
        n_job   = r_job;
        if (w_accept) begin
            n_job.c_real     = i_c_real;
            n_job.c_imag     = i_c_imag;
            n_job.zero_limit = (i_limit == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

@@ sv/mbe_queue.sv @@
// Two-entry job queue between the input stage and the iteration engine.
`timescale 1ns / 1ps

module mbe_queue import mbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ sv/mbe_core.sv @@
// Iteration engine: z = z*z + c, escape test, result register.
`timescale 1ns / 1ps

module mbe_core import mbe_pkg::*; #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  t_job                   i_job,
    output logic                   o_pop,
    input  logic [COUNT_WIDTH-1:0] i_limit,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_WIDTH-1:0] o_iter_count,
    output logic                   o_escaped
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic                      r_out_valid;
    logic                      n_out_valid;

    logic signed [COORD_W-1:0] r_cr;
    logic signed [COORD_W-1:0] n_cr;
    logic signed [COORD_W-1:0] r_ci;
    logic signed [COORD_W-1:0] n_ci;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] n_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] n_y;
    logic signed [PROD_W-1:0]  r_pxx;
    logic signed [PROD_W-1:0]  n_pxx;
    logic signed [PROD_W-1:0]  r_pyy;
    logic signed [PROD_W-1:0]  n_pyy;
    logic signed [PROD_W-1:0]  r_pxy;
    logic signed [PROD_W-1:0]  n_pxy;
    logic [COUNT_WIDTH-1:0]    r_iter;
    logic [COUNT_WIDTH-1:0]    n_iter;
    logic                      r_first;
    logic                      n_first;
    logic [COUNT_WIDTH-1:0]    r_res_count;
    logic [COUNT_WIDTH-1:0]    n_res_count;
    logic                      r_res_esc;
    logic                      n_res_esc;
    logic [COUNT_WIDTH-1:0]    r_out_count;
    logic [COUNT_WIDTH-1:0]    n_out_count;
    logic                      r_out_esc;
    logic                      n_out_esc;

    logic signed [PROD_W-1:0]  w_pxx;
    logic signed [PROD_W-1:0]  w_pyy;
    logic signed [PROD_W-1:0]  w_pxy;
    logic signed [SUM_W-1:0]   w_sqx;
    logic signed [SUM_W-1:0]   w_sqy;
    logic signed [SUM_W-1:0]   w_nx;
    logic signed [SUM_W-1:0]   w_ny;
    logic                      w_sq_esc;
    logic                      w_bound_esc;
    logic                      w_out_free;

    assign w_pxx = r_x * r_x;
    assign w_pyy = r_y * r_y;
    assign w_pxy = r_x * r_y;

    // floored squares of the current z; also the test for the previous iterate
    assign w_sqx    = SUM_W'(r_pxx >>> FRAC_BITS);
    assign w_sqy    = SUM_W'(r_pyy >>> FRAC_BITS);
    assign w_nx     = w_sqx - w_sqy + SUM_W'(r_cr);
    assign w_ny     = SUM_W'(r_pxy >>> (FRAC_BITS - 1)) + SUM_W'(r_ci);
    assign w_sq_esc = !r_first && ((w_sqx + w_sqy) > ESC_LIMIT);
    assign w_bound_esc = (w_nx >= BOUND_POS) || (w_nx <= BOUND_NEG) ||
                         (w_ny >= BOUND_POS) || (w_ny <= BOUND_NEG);

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_iter_count = r_out_count;
    assign o_escaped    = r_out_esc;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_x         = r_x;
        n_y         = r_y;
        n_pxx       = r_pxx;
        n_pyy       = r_pyy;
        n_pxy       = r_pxy;
        n_iter      = r_iter;
        n_first     = r_first;
        n_res_count = r_res_count;
        n_res_esc   = r_res_esc;
        n_out_count = r_out_count;
        n_out_esc   = r_out_esc;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_cr    = $signed(i_job.c_real);
                    n_ci    = $signed(i_job.c_imag);
                    n_x     = $signed(i_job.c_real);
                    n_y     = $signed(i_job.c_imag);
                    n_iter  = '0;
                    n_first = 1'b1;
                    if (i_job.zero_limit) begin
                        n_res_count = '0;
                        n_res_esc   = 1'b0;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_pxx   = w_pxx;
                n_pyy   = w_pyy;
                n_pxy   = w_pxy;
                n_state = S_ADD;
            end
            S_ADD: begin
                if (w_sq_esc) begin
                    n_res_count = r_iter - COUNT_WIDTH'(1);
                    n_res_esc   = 1'b1;
                    n_state     = S_DONE;
                end else if (r_iter == i_limit) begin
                    n_res_count = i_limit;
                    n_res_esc   = 1'b0;
                    n_state     = S_DONE;
                end else if (w_bound_esc) begin
                    n_res_count = r_iter;
                    n_res_esc   = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_x     = $signed(w_nx[COORD_W-1:0]);
                    n_y     = $signed(w_ny[COORD_W-1:0]);
                    n_iter  = r_iter + COUNT_WIDTH'(1);
                    n_first = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_res_count;
                    n_out_esc   = r_res_esc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr        <= n_cr;
        r_ci        <= n_ci;
        r_x         <= n_x;
        r_y         <= n_y;
        r_pxx       <= n_pxx;
        r_pyy       <= n_pyy;
        r_pxy       <= n_pxy;
        r_iter      <= n_iter;
        r_first     <= n_first;
        r_res_count <= n_res_count;
        r_res_esc   <= n_res_esc;
        r_out_count <= n_out_count;
        r_out_esc   <= n_out_esc;
    end

endmodule

@@ sv/mandelbrot_escape_time.sv @@
// Top level of the Mandelbrot escape-time unit: limit register, input stage, queue, engine.
//
//  Channel  Direction  Handshake                 Word
//  in       input      i_in_valid / o_in_stall   i_c_real, i_c_imag (Q3.28)
//  out      output     o_out_valid / i_out_stall o_iter_count, o_escaped
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (iteration limit)
//
// One point at a time in the engine: a load step, then per iteration a multiply
// step and an add-and-test step, then a retire step.
// The 32x32 multiply and the add/compare sit in separate states of each iteration.
// Reset is synchronous; the limit resets to 16. Up to three points wait ahead
// of the engine while the output is stalled.
`timescale 1ns / 1ps

module mandelbrot_escape_time import mbe_pkg::*; #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COORD_W-1:0]     i_c_real,
    input  logic [COORD_W-1:0]     i_c_imag,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_WIDTH-1:0] o_iter_count,
    output logic                   o_escaped,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [COUNT_WIDTH-1:0] i_cfg_data
);

    logic [COUNT_WIDTH-1:0] r_max_iterations;
    logic [COUNT_WIDTH-1:0] n_max_iterations;
    logic                   w_push;
    t_job                   w_front_job;
    logic                   w_queue_full;
    logic                   w_pop;
    logic                   w_queue_valid;
    t_job                   w_queue_job;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_max_iterations = r_max_iterations;
        if (i_cfg_valid && o_cfg_ready) begin
            n_max_iterations = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iterations <= COUNT_WIDTH'(RESET_LIMIT);
        end else begin
            r_max_iterations <= n_max_iterations;
        end
    end

    mbe_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_c_real     (i_c_real),
        .i_c_imag     (i_c_imag),
        .i_limit      (r_max_iterations),
        .o_push       (w_push),
        .o_job        (w_front_job),
        .i_queue_full (w_queue_full)
    );

    mbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_job   (w_queue_job)
    );

    mbe_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_queue_valid),
        .i_job        (w_queue_job),
        .o_pop        (w_pop),
        .i_limit      (r_max_iterations),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped)
    );

endmodule

@@ verif/mandelbrot_escape_time_tb.sv @@
// Self-checking testbench for the Mandelbrot escape-time unit.
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
    import mbe_pkg::*;

    localparam int CNT_W        = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LIMIT_RANDOM = -1;
    localparam int NUM_PHASES   = 9;
    localparam int TAIL_CYCLES  = 50;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [CNT_W-1:0] iter_count;
        logic             escaped;
    } t_escape_result;

    class escape_scoreboard;
        logic [CNT_W-1:0] limit;
        t_escape_result   pending_q[$];
        int               errors;

        function new();
            limit  = CNT_W'(RESET_LIMIT);
            errors = 0;
        endfunction

        // floor(a*b / 2^sh) on the exact 128-bit product
        function longint mul_floor(longint a, longint b, int sh);
            logic signed [127:0] wa, wb, prod;
            wa   = a;
            wb   = b;
            prod = wa * wb;
            return longint'(prod >>> sh);
        endfunction

        function t_escape_result escape_time(logic [COORD_W-1:0] re, logic [COORD_W-1:0] im);
            longint cr, ci, x, y, nx, ny, bound4, eight;
            bit esc;
            t_escape_result r;
            cr     = $signed(re);
            ci     = $signed(im);
            bound4 = 64'sd1 <<< (FRAC_BITS + 2);
            eight  = 64'sd8 <<< FRAC_BITS;
            x      = cr;
            y      = ci;
            r.iter_count = limit;
            r.escaped    = 1'b0;
            for (int i = 0; i < limit; i++) begin
                nx = mul_floor(x, x, FRAC_BITS) - mul_floor(y, y, FRAC_BITS) + cr;
                ny = mul_floor(x, y, FRAC_BITS - 1) + ci;
                if (nx >= bound4 || nx <= -bound4 || ny >= bound4 || ny <= -bound4) begin
                    esc = 1'b1;
                end else begin
                    esc = (mul_floor(nx, nx, FRAC_BITS) + mul_floor(ny, ny, FRAC_BITS)) > eight;
                end
                if (esc) begin
                    r.iter_count = CNT_W'(i);
                    r.escaped    = 1'b1;
                    return r;
                end
                x = nx;
                y = ny;
            end
            return r;
        endfunction

        function void note_point(logic [COORD_W-1:0] re, logic [COORD_W-1:0] im);
            pending_q.push_back(escape_time(re, im));
        endfunction

        function void check_result(logic [CNT_W-1:0] count, logic esc);
            t_escape_result want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual count %0d escaped %0b",
                         $time, count, esc);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (count !== want.iter_count) begin
                $display("%0t: iter_count expected %0d actual %0d",
                         $time, want.iter_count, count);
                errors++;
            end
            if (esc !== want.escaped) begin
                $display("%0t: escaped expected %0b actual %0b", $time, want.escaped, esc);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [COORD_W-1:0] i_c_real     = '0;
    logic [COORD_W-1:0] i_c_imag     = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [CNT_W-1:0]   o_iter_count;
    logic               o_escaped;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data   = '0;

    escape_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;

    mandelbrot_escape_time #(.COUNT_WIDTH(CNT_W)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_c_real     (i_c_real),
        .i_c_imag     (i_c_imag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[mandelbrot_escape_time] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_point(i_c_real, i_c_imag);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_iter_count, o_escaped);
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            IDLE_BOTH: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    task automatic send_point(input logic [COORD_W-1:0] re, input logic [COORD_W-1:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_c_real   <= re;
        i_c_imag   <= im;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly points near the set so that iterations run deep
    task automatic send_random_point();
        int sel;
        int re, im, ofs_re, ofs_im;
        sel    = $urandom_range(99);
        ofs_re = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        ofs_im = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        if (sel < 15) begin
            re = $urandom;
            im = $urandom;
        end else if (sel < 80) begin
            re = int'($urandom_range(0, 32'h3000_0000)) - 32'h2400_0000;
            im = int'($urandom_range(0, 32'h3000_0000)) - 32'h1800_0000;
        end else begin
            case ($urandom_range(4))
                0: begin re = 32'hF400_0000; im = 0;            end
                1: begin re = 32'h0400_0000; im = 0;            end
                2: begin re = 32'hE000_0000; im = 0;            end
                3: begin re = 0;             im = 32'h1000_0000; end
                default: begin re = 32'hFE09_D495; im = 32'h0BEB_2A9E; end
            endcase
            re = re + ofs_re;
            im = im + ofs_im;
        end
        send_point(re, im);
    endtask

    initial begin
        int phase_limit[NUM_PHASES];
        int phase_items[NUM_PHASES];
        int lim;
        phase_limit = '{0, 1, 5, 16, 64, LIMIT_RANDOM, 255, 4095, LIMIT_RANDOM};
        phase_items = '{20, 40, 60, 80, 90, 80, 40, 10, 100};
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit, corners and fixed points of the iteration
        set_idling(IDLE_NONE);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h7FFF_FFFF);
        send_point(32'hF000_0000, 32'h0000_0000);
        send_point(32'hE000_0000, 32'h0000_0000);
        send_point(32'hE000_0001, 32'h0000_0000);
        send_point(32'hDFFF_FFFF, 32'h0000_0000);
        send_point(32'h0400_0000, 32'h0000_0000);
        send_point(32'h04CC_CCCD, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h1000_0000);
        send_point(32'h0000_0000, 32'hE000_0000);
        send_point(32'h0000_0000, 32'h2000_0000);
        send_point(32'h1000_0000, 32'h1000_0000);
        send_point(32'hF000_0000, 32'hF000_0000);
        send_point(32'hD800_0000, 32'h0000_0000);
        send_point(32'h4000_0000, 32'h4000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0000_0001, 32'h0000_0001);
        send_point(32'hF400_0000, 32'h0010_0000);
        send_point(32'h5555_5555, 32'hAAAA_AAAA);
        wait_all_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            lim = (phase_limit[p] == LIMIT_RANDOM) ? $urandom_range(2, 48) : phase_limit[p];
            write_limit(CNT_W'(lim));
            set_idling(t_idle_mode'((p + 1) % 4));
            repeat (phase_items[p]) send_random_point();
            wait_all_results();
        end

        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("[mandelbrot_escape_time] OK");
        end else begin
            $display("[mandelbrot_escape_time] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/mbe_pkg.sv
sv/mbe_front.sv
sv/mbe_queue.sv
sv/mbe_core.sv
sv/mandelbrot_escape_time.sv
verif/mandelbrot_escape_time_tb.sv
